// ===== rtl/core/byte_stuffed_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_defines
// assertion macros shared by the frame receiver rtl
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BSFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfr_pkg
// types and constants of the byte-stuffed frame receiver
// ----------------------------------------------------------------------------
package bsfr_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int LEN_W       = 11;

	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_CODE  = 8'h7d;
	localparam logic [7:0] ESC_FLAG  = 8'h5e;
	localparam logic [7:0] ESC_ESC   = 8'h5d;

	localparam logic [7:0] ADDRESS_RESET = 8'h03;
	localparam logic [7:0] SEQ0_RESET    = 8'h00;
	localparam logic [7:0] SEQ1_RESET    = 8'h20;

	typedef enum logic [1:0] {
		REG_ADDRESS = 2'd0,
		REG_SEQ0    = 2'd1,
		REG_SEQ1    = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_FLAG = 3'd1,
		PH_ADDR = 3'd2,
		PH_CTRL = 3'd3,
		PH_DATA = 3'd4,
		PH_ESC  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BCC_ERR  = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

endpackage

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// destuffs line bytes, checks the frame header and bcc2, forwards payload bytes, reports frame ends
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata: rx_byte
// m_*      out  m_tvalid/m_tready  m_tuser: kind, m_tdata: data, seq, length
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one line byte per cycle while s_tready is high; each word is decoded in the cycle it is taken and
// its result (if any) sits in the output register the next cycle.
// s_tready stays high while the output register is empty or being drained.
// arst_n clears the parser to flag hunting and loads the register defaults.
// cfg_ready is always high; writes take effect on the next word.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_defines.svh"

module byte_stuffed_frame_receiver
	import bsfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] data_byte, [8] seq_bit, [19:9] frame_length
	output logic [1:0]  m_tuser,    // [1:0] kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] address_q, seq0_q, seq1_q;

	phase_t           phase_q, phase_d;
	logic             seq_q, seq_d;
	logic [7:0]       held_q, held_d;
	logic             held_valid_q, held_valid_d;
	logic [7:0]       xor_q, xor_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             ovf_q, ovf_d;

	logic             pay_req;
	logic [7:0]       pay_byte;
	logic             end_req;
	kind_t            end_kind;
	logic [7:0]       ctrl_sel;

	logic             res_valid;
	kind_t            res_kind;
	logic [7:0]       res_data;

	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [7:0]       out_data_q;
	logic             out_seq_q;
	logic [LEN_W-1:0] out_len_q;

	logic acc;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign acc       = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ADDRESS_RESET;
			seq0_q    <= SEQ0_RESET;
			seq1_q    <= SEQ1_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ADDRESS: address_q <= cfg_data;
				REG_SEQ0:    seq0_q    <= cfg_data;
				REG_SEQ1:    seq1_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_comb begin
		phase_d      = phase_q;
		seq_d        = seq_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		xor_d        = xor_q;
		count_d      = count_q;
		ovf_d        = ovf_q;
		pay_req      = 1'b0;
		pay_byte     = held_q;
		end_req      = 1'b0;
		end_kind     = KIND_BCC_ERR;
		ctrl_sel     = seq_q ? seq1_q : seq0_q;

		unique case (phase_q)
			PH_FLAG: begin
				// a repeated flag keeps waiting for the address
				if (s_tdata == address_q)       phase_d = PH_ADDR;
				else if (s_tdata != FLAG_BYTE)  phase_d = PH_HUNT;
			end
			PH_ADDR: begin
				// equal control registers: sequence zero wins
				priority if (s_tdata == seq0_q) begin
					seq_d   = 1'b0;
					phase_d = PH_CTRL;
				end else if (s_tdata == seq1_q) begin
					seq_d   = 1'b1;
					phase_d = PH_CTRL;
				end else begin
					phase_d = (s_tdata == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_CTRL: begin
				if (s_tdata == (address_q ^ ctrl_sel)) begin
					phase_d      = PH_DATA;
					held_d       = '0;
					held_valid_d = 1'b0;
					xor_d        = '0;
					count_d      = '0;
					ovf_d        = 1'b0;
				end else begin
					phase_d = (s_tdata == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
				end
			end
			PH_DATA: begin
				priority if (s_tdata == FLAG_BYTE) begin
					// held byte is bcc2
					end_req = 1'b1;
					priority if (ovf_q)                         end_kind = KIND_OVERFLOW;
					else if (held_valid_q && held_q == xor_q)   end_kind = KIND_GOOD;
					else                                        end_kind = KIND_BCC_ERR;
					held_valid_d = 1'b0;
					phase_d      = PH_FLAG;
				end else if (s_tdata == ESC_CODE) begin
					pay_req      = held_valid_q;
					held_valid_d = 1'b0;
					phase_d      = PH_ESC;
				end else begin
					pay_req      = held_valid_q;
					held_d       = s_tdata;
					held_valid_d = 1'b1;
				end
			end
			PH_ESC: begin
				priority if (s_tdata == ESC_FLAG) begin
					held_d       = FLAG_BYTE;
					held_valid_d = 1'b1;
					phase_d      = PH_DATA;
				end else if (s_tdata == ESC_ESC) begin
					held_d       = ESC_CODE;
					held_valid_d = 1'b1;
					phase_d      = PH_DATA;
				end else if (s_tdata == FLAG_BYTE) begin
					// abort inside an escape
					end_req      = 1'b1;
					end_kind     = ovf_q ? KIND_OVERFLOW : KIND_BCC_ERR;
					held_valid_d = 1'b0;
					phase_d      = PH_FLAG;
				end else if (s_tdata == ESC_CODE) begin
					pay_req  = 1'b1;
					pay_byte = ESC_CODE;
				end else begin
					// unknown escape: keep both bytes
					pay_req      = 1'b1;
					pay_byte     = ESC_CODE;
					held_d       = s_tdata;
					held_valid_d = 1'b1;
					phase_d      = PH_DATA;
				end
			end
			default: begin
				phase_d = (s_tdata == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
			end
		endcase

		res_valid = end_req;
		res_kind  = end_kind;
		res_data  = '0;
		if (pay_req) begin
			if (count_q >= CNT_W'(MAX_PAYLOAD)) begin
				ovf_d = 1'b1;
			end else begin
				count_d   = count_q + CNT_W'(1);
				xor_d     = xor_q ^ pay_byte;
				res_valid = 1'b1;
				res_kind  = KIND_PAYLOAD;
				res_data  = pay_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			seq_q        <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			xor_q        <= '0;
			count_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (acc) begin
			phase_q      <= phase_d;
			seq_q        <= seq_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			xor_q        <= xor_d;
			count_q      <= count_d;
			ovf_q        <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && res_valid) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
			out_seq_q  <= seq_d;
			out_len_q  <= LEN_W'(count_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {4'b0000, out_len_q, out_seq_q, out_data_q};

	`BSFR_ASSERT_NOW(a_payload_counted, clk, arst_n,
		m_tvalid && out_kind_q == KIND_PAYLOAD, out_len_q != '0, "payload word with zero length")
	`BSFR_ASSERT_NOW(a_end_data_zero, clk, arst_n,
		m_tvalid && out_kind_q != KIND_PAYLOAD, out_data_q == '0, "frame end carries data")
	`BSFR_ASSERT_NOW(a_count_bound, clk, arst_n,
		1'b1, count_q <= CNT_W'(MAX_PAYLOAD), "payload count past limit")
	`BSFR_ASSERT_NOW(a_held_in_data, clk, arst_n,
		held_valid_q, phase_q == PH_DATA, "held byte outside payload phase")
	`BSFR_ASSERT_NEXT(a_end_to_flag, clk, arst_n,
		acc && end_req, phase_q == PH_FLAG, "frame end did not reopen at flag")

endmodule
